// ----- hdl/drd_pkg.sv -----
// Shared types, widths, register indexes and helpers for the detection row decoder.
package drd_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int SLOTS      = 8;
    localparam int CAND_N     = SLOTS / 2;
    localparam int CLASS_W    = 3;
    localparam int IN_W       = 16;
    localparam int MAG_W      = FRAC_BITS + 1;
    localparam int SCORE_W    = 15;
    localparam int PIX_W      = 13;
    localparam int CTR_W      = 27;
    localparam int DIFF_W     = 18;
    localparam int MUL_W      = MAG_W + PIX_W;
    localparam int CMUL_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_THRESHOLD = 2'd0;
    localparam t_cfg_idx CFG_FRAME_W   = 2'd1;
    localparam t_cfg_idx CFG_FRAME_H   = 2'd2;

    localparam logic [SCORE_W-1:0] THRESHOLD_RST = 15'd7373;
    localparam logic [PIX_W-1:0]   FRAME_RST     = 13'd640;

    typedef logic [CLASS_W-1:0] t_cls;
    typedef logic [SCORE_W-1:0] t_score;

    typedef struct packed {
        t_score val;
        t_cls   idx;
    } t_cand;

    typedef struct packed {
        logic signed [IN_W-1:0] norm_center_x;
        logic signed [IN_W-1:0] norm_center_y;
        logic signed [IN_W-1:0] norm_width;
        logic signed [IN_W-1:0] norm_height;
        logic signed [IN_W-1:0] score_0;
        logic signed [IN_W-1:0] score_1;
        logic signed [IN_W-1:0] score_2;
        logic signed [IN_W-1:0] score_3;
        logic signed [IN_W-1:0] score_4;
        logic signed [IN_W-1:0] score_5;
        logic signed [IN_W-1:0] score_6;
        logic signed [IN_W-1:0] score_7;
    } t_row;

    typedef struct packed {
        t_cls             class_index;
        t_score           best_score;
        logic [PIX_W-1:0] box_left;
        logic [PIX_W-1:0] box_top;
        logic [PIX_W-1:0] box_pixel_width;
        logic [PIX_W-1:0] box_pixel_height;
        logic [CTR_W-1:0] pixel_center_x;
        logic [CTR_W-1:0] pixel_center_y;
    } t_det;

    typedef struct packed {
        t_score           threshold;
        logic [PIX_W-1:0] frame_width;
        logic [PIX_W-1:0] frame_height;
    } t_cfg;

    // first stage: range-checked geometry and half-reduced argmax
    typedef struct packed {
        logic [MAG_W-1:0]         cx;
        logic [MAG_W-1:0]         cy;
        logic [MAG_W-1:0]         w;
        logic [MAG_W-1:0]         h;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        t_cand [CAND_N-1:0]       cand;
    } t_s1;

    // second stage: products and final argmax
    typedef struct packed {
        t_cand                    best;
        logic signed [CMUL_W-1:0] prod_l;
        logic signed [CMUL_W-1:0] prod_t;
        logic [MUL_W-1:0]         prod_w;
        logic [MUL_W-1:0]         prod_h;
        logic [MUL_W-1:0]         prod_cx;
        logic [MUL_W-1:0]         prod_cy;
    } t_s2;

    // strict greater: the earlier candidate keeps ties
    function automatic t_cand pick(t_cand a, t_cand b);
        return (b.val > a.val) ? b : a;
    endfunction

endpackage

// ----- hdl/drd_if.sv -----
// Channel interfaces: row input, detection output and register write port.
interface drd_row_if import drd_pkg::*; ();
    logic valid;
    logic ready;
    t_row data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface drd_det_if import drd_pkg::*; ();
    logic valid;
    logic ready;
    t_det data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface drd_cfg_if import drd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hdl/drd_select.sv -----
// Stage 1: coordinate range check, score clamp and first argmax level.
module drd_select import drd_pkg::*; #(
    parameter int CLASS_COUNT = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_row i_row,
    output logic o_valid,
    input  logic i_ready,
    output t_s1  o_data
);

    localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

    logic                   r_valid;
    t_s1                    r_data;
    t_s1                    n_data;
    logic                   n_keep;
    logic signed [IN_W-1:0] score [SLOTS];
    t_cand                  leaf [SLOTS];

    function automatic logic in_unit(logic signed [IN_W-1:0] v);
        return !v[IN_W-1] && (32'(v[MAG_W-1:0]) <= ONE_Q);
    endfunction

    always_comb begin
        score[0] = i_row.score_0;
        score[1] = i_row.score_1;
        score[2] = i_row.score_2;
        score[3] = i_row.score_3;
        score[4] = i_row.score_4;
        score[5] = i_row.score_5;
        score[6] = i_row.score_6;
        score[7] = i_row.score_7;

        n_keep = in_unit(i_row.norm_center_x) && in_unit(i_row.norm_center_y) &&
                 in_unit(i_row.norm_width) && in_unit(i_row.norm_height);

        // scores at or below zero can never win, nor can unused slots
        for (int j = 0; j < SLOTS; j++) begin
            leaf[j].val = (j < CLASS_COUNT && !score[j][IN_W-1]) ? score[j][SCORE_W-1:0] : '0;
            leaf[j].idx = CLASS_W'(j);
        end

        n_data.cx = i_row.norm_center_x[MAG_W-1:0];
        n_data.cy = i_row.norm_center_y[MAG_W-1:0];
        n_data.w  = i_row.norm_width[MAG_W-1:0];
        n_data.h  = i_row.norm_height[MAG_W-1:0];
        n_data.dx = $signed({2'b00, n_data.cx, 1'b0}) - $signed({3'b000, n_data.w});
        n_data.dy = $signed({2'b00, n_data.cy, 1'b0}) - $signed({3'b000, n_data.h});
        for (int k = 0; k < CAND_N; k++) begin
            n_data.cand[k] = pick(leaf[2*k], leaf[2*k+1]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/drd_scale.sv -----
// Stage 2: frame-size products and the last argmax levels.
module drd_scale import drd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_s1              i_data,
    input  logic [PIX_W-1:0] i_frame_width,
    input  logic [PIX_W-1:0] i_frame_height,
    output logic             o_valid,
    input  logic             i_ready,
    output t_s2              o_data
);

    logic                     r_valid;
    t_s2                      r_data;
    t_s2                      n_data;
    logic signed [CMUL_W-1:0] dx_ext;
    logic signed [CMUL_W-1:0] dy_ext;
    logic signed [CMUL_W-1:0] fw_ext;
    logic signed [CMUL_W-1:0] fh_ext;

    always_comb begin
        dx_ext = {{(CMUL_W-DIFF_W){i_data.dx[DIFF_W-1]}}, i_data.dx};
        dy_ext = {{(CMUL_W-DIFF_W){i_data.dy[DIFF_W-1]}}, i_data.dy};
        fw_ext = {{(CMUL_W-PIX_W){1'b0}}, i_frame_width};
        fh_ext = {{(CMUL_W-PIX_W){1'b0}}, i_frame_height};

        n_data.best    = pick(pick(i_data.cand[0], i_data.cand[1]),
                              pick(i_data.cand[2], i_data.cand[3]));
        n_data.prod_l  = dx_ext * fw_ext;
        n_data.prod_t  = dy_ext * fh_ext;
        n_data.prod_w  = MUL_W'(i_data.w)  * MUL_W'(i_frame_width);
        n_data.prod_h  = MUL_W'(i_data.h)  * MUL_W'(i_frame_height);
        n_data.prod_cx = MUL_W'(i_data.cx) * MUL_W'(i_frame_width);
        n_data.prod_cy = MUL_W'(i_data.cy) * MUL_W'(i_frame_height);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/drd_emit.sv -----
// Stage 3: threshold test, corner clamp, fraction shifts and the output register.
module drd_emit import drd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_s2    i_data,
    input  t_score i_threshold,
    output logic   o_valid,
    input  logic   i_ready,
    output t_det   o_det
);

    logic              r_valid;
    t_det              r_det;
    t_det              n_det;
    logic              n_keep;
    logic [CMUL_W-1:0] l_sh;
    logic [CMUL_W-1:0] t_sh;
    logic [MUL_W-1:0]  w_sh;
    logic [MUL_W-1:0]  h_sh;

    always_comb begin
        n_keep = (i_data.best.val != '0) && (i_data.best.val >= i_threshold);

        l_sh = $unsigned(i_data.prod_l) >> (FRAC_BITS + 1);
        t_sh = $unsigned(i_data.prod_t) >> (FRAC_BITS + 1);
        w_sh = i_data.prod_w >> FRAC_BITS;
        h_sh = i_data.prod_h >> FRAC_BITS;

        n_det.class_index      = i_data.best.idx;
        n_det.best_score       = i_data.best.val;
        // left/top edge clamps at zero when the product is not positive
        n_det.box_left         = (!i_data.prod_l[CMUL_W-1] && i_data.prod_l != '0)
                                 ? l_sh[PIX_W-1:0] : '0;
        n_det.box_top          = (!i_data.prod_t[CMUL_W-1] && i_data.prod_t != '0)
                                 ? t_sh[PIX_W-1:0] : '0;
        n_det.box_pixel_width  = w_sh[PIX_W-1:0];
        n_det.box_pixel_height = h_sh[PIX_W-1:0];
        n_det.pixel_center_x   = i_data.prod_cx[CTR_W-1:0];
        n_det.pixel_center_y   = i_data.prod_cy[CTR_W-1:0];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_det <= n_det;
        end
    end

    assign o_valid = r_valid;
    assign o_det   = r_det;

endmodule

// ----- hdl/detection_row_decode.sv -----
// Detection row decoder: three-stage pipeline: range check, argmax, scaling, threshold.
// An accepted row passes the select, scale and emit stage registers in that order.
// Throughput: one row per cycle unless the output stalls; each stage is a register
// with its own valid bit; ready runs back combinationally through the stage registers.
// Rows that fail the range check or the score test leave no word behind.
// Synchronous active-low reset clears the valid bits; threshold 7373, frame 640 x 640.
module detection_row_decode import drd_pkg::*; #(
    parameter int CLASS_COUNT = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    drd_row_if.sink   i_row,
    drd_det_if.source o_det,
    drd_cfg_if.sink   i_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;
    logic s2_valid;
    logic s2_ready;
    t_s2  s2_data;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_THRESHOLD: n_cfg.threshold    = i_cfg.data[SCORE_W-1:0];
                CFG_FRAME_W:   n_cfg.frame_width  = i_cfg.data[PIX_W-1:0];
                CFG_FRAME_H:   n_cfg.frame_height = i_cfg.data[PIX_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= THRESHOLD_RST;
            r_cfg.frame_width  <= FRAME_RST;
            r_cfg.frame_height <= FRAME_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    drd_select #(
        .CLASS_COUNT(CLASS_COUNT)
    ) u_select (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_row.valid),
        .o_ready(i_row.ready),
        .i_row  (i_row.data),
        .o_valid(s1_valid),
        .i_ready(s1_ready),
        .o_data (s1_data)
    );

    drd_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s1_valid),
        .o_ready       (s1_ready),
        .i_data        (s1_data),
        .i_frame_width (r_cfg.frame_width),
        .i_frame_height(r_cfg.frame_height),
        .o_valid       (s2_valid),
        .i_ready       (s2_ready),
        .o_data        (s2_data)
    );

    drd_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s2_valid),
        .o_ready    (s2_ready),
        .i_data     (s2_data),
        .i_threshold(r_cfg.threshold),
        .o_valid    (o_det.valid),
        .i_ready    (o_det.ready),
        .o_det      (o_det.data)
    );

endmodule

// ----- tb/tb_detection_row_decode.sv -----
// Self-checking testbench for the detection row decoder: directed rows, random rows, register phases.
module tb_detection_row_decode import drd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLASS_COUNT  = 8;
    localparam int FRAC         = 14;
    localparam int ONE          = 1 << FRAC;
    localparam int LATENCY      = 3;
    localparam int DRAIN_CYCLES = 2 * LATENCY + 4;
    localparam int PHASES       = 10;
    localparam int PHASE_ROWS   = 130;

    // row as raw words: word 11 is the centre x, word 7 - j is score j
    localparam int W_CX     = 11;
    localparam int W_SCORE0 = 7;
    typedef logic [11:0][IN_W-1:0] t_row_words;

    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    // predictor and store of pending detection words
    class detection_board;
        t_det upcoming[$];
        int   thr;
        int   fw;
        int   fh;
        int   errors;

        function new();
            thr    = THRESHOLD_RST;
            fw     = FRAME_RST;
            fh     = FRAME_RST;
            errors = 0;
        endfunction

        function int pending();
            return upcoming.size();
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_THRESHOLD: thr = val[SCORE_W-1:0];
                CFG_FRAME_W:   fw  = val[PIX_W-1:0];
                CFG_FRAME_H:   fh  = val[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        function bit in_unit(int v);
            return (v >= 0) && (v <= ONE);
        endfunction

        // corner pixel: truncated, nothing below zero
        function longint corner(int c, int s, int size);
            longint p;
            p = (2 * longint'(c) - s) * size;
            return (p <= 0) ? 0 : (p >>> (FRAC + 1));
        endfunction

        function void note_row(t_row r);
            int                     cx, cy, w, h, best, win, s;
            logic signed [IN_W-1:0] sc [SLOTS];
            t_det                   d;
            cx = $signed(r.norm_center_x);
            cy = $signed(r.norm_center_y);
            w  = $signed(r.norm_width);
            h  = $signed(r.norm_height);
            sc = '{r.score_0, r.score_1, r.score_2, r.score_3,
                   r.score_4, r.score_5, r.score_6, r.score_7};
            if (!in_unit(cx) || !in_unit(cy) || !in_unit(w) || !in_unit(h))
                return;
            best = 0;
            win  = 0;
            for (int j = 0; j < CLASS_COUNT; j++) begin
                s = $signed(sc[j]);
                if (s > best) begin
                    best = s;
                    win  = j;
                end
            end
            if (best == 0 || best < thr)
                return;
            d.class_index      = CLASS_W'(win);
            d.best_score       = SCORE_W'(best);
            d.box_left         = PIX_W'(corner(cx, w, fw));
            d.box_top          = PIX_W'(corner(cy, h, fh));
            d.box_pixel_width  = PIX_W'((longint'(w) * fw) >>> FRAC);
            d.box_pixel_height = PIX_W'((longint'(h) * fh) >>> FRAC);
            d.pixel_center_x   = CTR_W'(longint'(cx) * fw);
            d.pixel_center_y   = CTR_W'(longint'(cy) * fh);
            upcoming = {upcoming, d};
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task cmp_field(string name, longint got, longint want);
            if (got != want)
                report($sformatf("%s got %0d, expected %0d", name, got, want));
        endtask

        task check(t_det got);
            t_det want;
            if (upcoming.size() == 0) begin
                report("detection word with nothing pending");
                return;
            end
            want = upcoming.pop_front();
            cmp_field("class_index", got.class_index, want.class_index);
            cmp_field("best_score", got.best_score, want.best_score);
            cmp_field("box_left", got.box_left, want.box_left);
            cmp_field("box_top", got.box_top, want.box_top);
            cmp_field("box_pixel_width", got.box_pixel_width, want.box_pixel_width);
            cmp_field("box_pixel_height", got.box_pixel_height, want.box_pixel_height);
            cmp_field("pixel_center_x", got.pixel_center_x, want.pixel_center_x);
            cmp_field("pixel_center_y", got.pixel_center_y, want.pixel_center_y);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    drd_row_if row_if();
    drd_det_if det_if();
    drd_cfg_if cfg_if();

    detection_board board;
    bit             src_free;
    bit             sink_free;
    int             sink_hold = 0;

    detection_row_decode #(
        .CLASS_COUNT(CLASS_COUNT)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_row  (row_if),
        .o_det  (det_if),
        .i_cfg  (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unit_val();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return ONE;
        return $urandom_range(0, ONE);
    endfunction

    function automatic t_row mk_row(int cx, int cy, int w, int h, int other);
        t_row_words wd;
        wd[W_CX]     = IN_W'(cx);
        wd[W_CX - 1] = IN_W'(cy);
        wd[W_CX - 2] = IN_W'(w);
        wd[W_CX - 3] = IN_W'(h);
        for (int j = 0; j < SLOTS; j++)
            wd[W_SCORE0 - j] = IN_W'(other);
        return t_row'(wd);
    endfunction

    function automatic t_row with_score(t_row r, int j, int v);
        t_row_words wd;
        wd = t_row_words'(r);
        wd[W_SCORE0 - j] = IN_W'(v);
        return t_row'(wd);
    endfunction

    function automatic t_row rand_row();
        t_row_words wd;
        int         kind, v, top, slot;
        kind = $urandom_range(0, 99);
        for (int k = 0; k < 4; k++)
            wd[W_CX - k] = (kind < 85) ? IN_W'(unit_val()) : IN_W'($urandom);
        case ($urandom_range(0, 9))
            5: begin
                for (int j = 0; j < SLOTS; j++)
                    wd[W_SCORE0 - j] = IN_W'($urandom);
            end
            6: begin
                // nothing positive
                for (int j = 0; j < SLOTS; j++)
                    wd[W_SCORE0 - j] = IN_W'(-$urandom_range(0, 32768));
            end
            7: begin
                // slots take a shared top value at random, so ties are likely
                v = $urandom_range(1, 32767);
                for (int j = 0; j < SLOTS; j++)
                    wd[W_SCORE0 - j] = ($urandom_range(0, 2) == 0) ?
                                       IN_W'(v) : IN_W'($urandom_range(0, v - 1));
            end
            8: begin
                // best score at the threshold or one either side of it
                top = board.thr + $urandom_range(0, 2) - 1;
                if (top < 1) top = 1;
                if (top > 32767) top = 32767;
                for (int j = 0; j < SLOTS; j++)
                    wd[W_SCORE0 - j] = IN_W'($urandom_range(0, top - 1));
                slot = $urandom_range(0, SLOTS - 1);
                wd[W_SCORE0 - slot] = IN_W'(top);
            end
            9: begin
                for (int j = 0; j < SLOTS; j++)
                    wd[W_SCORE0 - j] = IN_W'($urandom);
                slot = $urandom_range(0, SLOTS - 1);
                wd[W_SCORE0 - slot] = IN_W'(32767);
            end
            default: begin
                for (int j = 0; j < SLOTS; j++)
                    wd[W_SCORE0 - j] = ($urandom_range(0, 4) == 0) ?
                                       IN_W'($urandom) : IN_W'($urandom_range(0, 32767));
            end
        endcase
        return t_row'(wd);
    endfunction

    task automatic send_row(t_row r);
        int gap;
        row_if.valid <= 1'b1;
        row_if.data  <= r;
        do @(posedge i_clk); while (!row_if.ready);
        board.note_row(r);
        gap = src_free ? 0 : gap_len();
        if (gap > 0) begin
            row_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // valid is left high so back-to-back writes need no extra edge
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        board.set_reg(idx, val);
    endtask

    task automatic drain_results();
        row_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(int p);
        drain_results();
        case (p)
            0: begin
                write_reg(CFG_THRESHOLD, 15'd0);
                write_reg(CFG_FRAME_W, 15'd0);
                write_reg(CFG_FRAME_H, 15'd4096);
            end
            1: begin
                write_reg(CFG_THRESHOLD, 15'd32767);
                write_reg(CFG_FRAME_W, 15'd8191);
                write_reg(CFG_FRAME_H, 15'd1);
            end
            2: begin
                // upper data bits are dropped: 4096 and 640 land in the frame registers
                write_reg(CFG_THRESHOLD, 15'd1);
                write_reg(CFG_FRAME_W, 15'h3000);
                write_reg(CFG_FRAME_H, 15'h6280);
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            end
            3: begin
                write_reg(CFG_THRESHOLD, THRESHOLD_RST);
                write_reg(CFG_FRAME_W, 15'd640);
                write_reg(CFG_FRAME_H, 15'd480);
            end
            default: begin
                write_reg(CFG_THRESHOLD, ($urandom_range(0, 3) == 0) ?
                          CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, ONE)));
                write_reg(CFG_FRAME_W, ($urandom_range(0, 9) < 7) ?
                          CFG_DATA_W'($urandom_range(1, 4096)) : CFG_DATA_W'($urandom));
                write_reg(CFG_FRAME_H, ($urandom_range(0, 9) < 7) ?
                          CFG_DATA_W'($urandom_range(1, 4096)) : CFG_DATA_W'($urandom));
                if ($urandom_range(0, 1) == 0)
                    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            end
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_directed();
        t_row r;
        r = with_score(mk_row(0, 0, 0, 0, -5), 0, THRESHOLD_RST);
        send_row(r);                                      // equal to threshold
        send_row(with_score(mk_row(0, 0, 0, 0, -5), 0, THRESHOLD_RST - 1));
        send_row(with_score(mk_row(ONE, ONE, ONE, ONE, 0), 7, 32767));
        send_row(mk_row(ONE + 1, ONE, ONE, ONE, 20000));  // out of range
        send_row(mk_row(ONE, -1, ONE, ONE, 20000));
        send_row(mk_row(ONE, ONE, -32768, ONE, 20000));
        send_row(mk_row(ONE, ONE, ONE, 32767, 20000));
        send_row(mk_row(8192, 8192, 4096, 4096, -32768)); // nothing positive
        send_row(mk_row(8192, 8192, 4096, 4096, 0));
        send_row(mk_row(8192, 8192, 4096, 4096, 10000));  // all tied
        r = with_score(mk_row(4000, 5000, 3000, 2000, 100), 3, 20000);
        send_row(with_score(r, 5, 20000));
        // left edge clamps at zero, top edge at the far side
        send_row(with_score(mk_row(100, ONE, ONE, 0, 0), 2, 12000));
        for (int j = 0; j < CLASS_COUNT; j++)
            send_row(with_score(mk_row(unit_val(), unit_val(), unit_val(), unit_val(), 8000),
                                j, 9000 + 100 * j));
    endtask

    // result side: check every accepted word, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && det_if.valid && det_if.ready)
            board.check(det_if.data);
        if (!i_rst_n) begin
            det_if.ready <= 1'b0;
            sink_hold    <= 0;
        end else if (sink_free) begin
            det_if.ready <= 1'b1;
            sink_hold    <= 0;
        end else if (sink_hold == 0) begin
            det_if.ready <= !det_if.ready;
            sink_hold    <= det_if.ready ? gap_len() : $urandom_range(0, 6);
        end else begin
            sink_hold <= sink_hold - 1;
        end
    end

    initial begin
        int rows;
        row_if.valid <= 1'b0;
        row_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_THRESHOLD;
        cfg_if.data  <= '0;
        src_free     <= 1'b0;
        sink_free    <= 1'b0;
        i_rst_n      <= 1'b0;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            apply_setting(p);
            src_free  <= (p % 3 == 2);
            sink_free <= (p % 4 == 1);
            rows = (p == 1) ? 40 : PHASE_ROWS;
            for (int k = 0; k < rows; k++) begin
                send_row(rand_row());
                // hold off until the pipe has emptied
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
        end

        drain_results();
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #8ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/drd_pkg.sv
hdl/drd_if.sv
hdl/drd_select.sv
hdl/drd_scale.sv
hdl/drd_emit.sv
hdl/detection_row_decode.sv
tb/tb_detection_row_decode.sv
